// File: sv/lfda_pkg.sv
// constants and codes shared by the lowest-free descriptor allocator
package lfda_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int ID_W     = 10;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;
	localparam int FDR_W    = 11;
	localparam int CFG_W    = 32;
	localparam int PADDR_W  = 3;

	localparam int ROW_W = 32;
	localparam int BIT_W = 5;

	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_ATTACH  = 3'd1;
	localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_HAS_HND   = 3'd4;

	localparam logic [FDR_W-1:0] NO_FD = '1;

	localparam logic REG_MIN_ID = 1'b0;
	localparam logic REG_MAX_ID = 1'b1;

endpackage

// File: sv/lowest_free_descriptor_allocator.sv
// lowest-free descriptor allocator: used-bit and handle memories with a sequencer
//
// One item at a time. Attach, replace, remove and lookup on a managed number keep busy
// high in the exec state after the accept (read of both memories, then modify and
// write back); the result strobe comes in the cycle after that state. Allocate scans
// the used-bit memory one 32-entry row per cycle through its single read port, so busy
// stays high until a free bit is found or the last row of the span has been scanned,
// span being the number of managed descriptors. An item with an unmanaged number or an
// unassigned op, and allocate on an empty range, keeps busy low and gives its result in
// the next cycle. After reset the used-bit memory is cleared one row per cycle with busy
// high until the last row is cleared; register writes are taken meanwhile. done is high
// for exactly one cycle per item and cannot be held off.
module lowest_free_descriptor_allocator
	import lfda_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [CFG_W-1:0]       pwdata,
	output logic [CFG_W-1:0]       prdata,
	output logic                   pready,
	input  logic                   start,
	output logic                   busy,
	input  logic [OP_W-1:0]        op,
	input  logic [ID_W-1:0]        fd,
	input  logic [HANDLE_BITS-1:0] handle,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic signed [FDR_W-1:0] fd_result,
	output logic [HANDLE_BITS-1:0] handle_out,
	output logic                   known,
	output logic [HANDLE_BITS-1:0] ref_add,
	output logic [HANDLE_BITS-1:0] ref_drop
);

	localparam int ROWS   = (DEPTH + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
	localparam logic [FDR_W-1:0]  DEPTH_N  = FDR_W'(DEPTH);
	localparam logic [FDR_W-1:0]  ROW_N    = FDR_W'(ROW_W);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	state_t                  state_q;
	logic [ID_W-1:0]         min_id_q;
	logic [ID_W-1:0]         max_id_q;
	logic [OP_W-1:0]         op_q;
	logic [ID_W-1:0]         slot_q;
	logic [HANDLE_BITS-1:0]  hnd_q;
	logic [ROW_AW-1:0]       row_q;

	logic [ROW_W-1:0]        used_mem [ROWS];
	logic [HANDLE_BITS-1:0]  hnd_mem [DEPTH];
	logic [ROW_W-1:0]        used_rdata_q;
	logic [HANDLE_BITS-1:0]  hnd_rdata_q;

	logic                    used_we;
	logic [ROW_AW-1:0]       used_wr_addr;
	logic [ROW_W-1:0]        used_wdata;
	logic [ROW_AW-1:0]       used_rd_addr;
	logic                    hnd_we;
	logic [IDX_AW-1:0]       hnd_wr_addr;
	logic [HANDLE_BITS-1:0]  hnd_wdata;
	logic [IDX_AW-1:0]       hnd_rd_addr;

	logic                    cfg_wr;
	logic                    accept;
	logic [FDR_W-1:0]        span_n;
	logic [FDR_W-1:0]        fd_off;
	logic                    fd_in;
	logic [FDR_W-1:0]        base;
	logic [FDR_W-1:0]        rem;
	logic [FDR_W-1:0]        next_base;
	logic [ROW_W-1:0]        avail;
	logic [ROW_W-1:0]        low_bit;
	logic [BIT_W-1:0]        low_idx;
	logic                    found;
	logic [FDR_W-1:0]        alloc_slot;
	logic [ROW_W-1:0]        slot_bit;
	logic                    cur_used;
	logic                    cur_null;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_ID) begin
			prdata[ID_W-1:0] = max_id_q;
		end else begin
			prdata[ID_W-1:0] = min_id_q;
		end
	end

	// managed count and range check
	always_comb begin
		if (max_id_q < min_id_q) begin
			span_n = '0;
		end else if (({1'b0, max_id_q} - {1'b0, min_id_q}) >= DEPTH_N) begin
			span_n = DEPTH_N;
		end else begin
			span_n = {1'b0, max_id_q} - {1'b0, min_id_q} + FDR_W'(1);
		end
		fd_off = {1'b0, fd} - {1'b0, min_id_q};
		fd_in  = (fd >= min_id_q) && (fd <= max_id_q) && (fd_off < DEPTH_N);
	end

	// lowest free bit of the row under scan
	always_comb begin
		base      = FDR_W'({row_q, {BIT_W{1'b0}}});
		rem       = span_n - base;
		next_base = base + ROW_N;
		for (int b = 0; b < ROW_W; b++) begin
			avail[b] = !used_rdata_q[b] && (FDR_W'(b) < rem);
		end
		found   = |avail;
		low_bit = avail & (~avail + ROW_W'(1));
		low_idx = '0;
		for (int b = 0; b < ROW_W; b++) begin
			for (int k = 0; k < BIT_W; k++) begin
				if (((b >> k) & 1) == 1) begin
					low_idx[k] = low_idx[k] | low_bit[b];
				end
			end
		end
		alloc_slot = base + FDR_W'(low_idx);
		slot_bit   = ROW_W'(1) << slot_q[BIT_W-1:0];
		cur_used   = used_rdata_q[slot_q[BIT_W-1:0]];
		cur_null   = (hnd_rdata_q == '0);
	end

	// memory port control
	always_comb begin
		used_rd_addr = ROW_AW'(fd_off >> BIT_W);
		if (state_q == ST_SCAN) begin
			used_rd_addr = row_q + ROW_AW'(1);
		end else if (op == OP_ALLOC) begin
			used_rd_addr = '0;
		end
		hnd_rd_addr = IDX_AW'(fd_off);

		used_we      = 1'b0;
		used_wr_addr = ROW_AW'(slot_q >> BIT_W);
		used_wdata   = used_rdata_q;
		hnd_we       = 1'b0;
		hnd_wr_addr  = IDX_AW'(slot_q);
		hnd_wdata    = hnd_q;
		unique case (state_q)
			ST_CLEAR: begin
				used_we      = 1'b1;
				used_wr_addr = row_q;
				used_wdata   = '0;
			end
			ST_SCAN: begin
				used_wr_addr = row_q;
				used_wdata   = used_rdata_q | low_bit;
				hnd_wr_addr  = IDX_AW'(alloc_slot);
				hnd_wdata    = '0;
				if (found) begin
					used_we = 1'b1;
					hnd_we  = 1'b1;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_ATTACH: begin
						used_wdata = used_rdata_q | slot_bit;
						if (!cur_used || cur_null) begin
							used_we = 1'b1;
							hnd_we  = 1'b1;
						end
					end
					OP_REPLACE: begin
						if (cur_used && !cur_null && (hnd_rdata_q != hnd_q)) begin
							hnd_we = 1'b1;
						end
					end
					OP_REMOVE: begin
						used_wdata = used_rdata_q & ~slot_bit;
						if (cur_used) begin
							used_we = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wr_addr] <= used_wdata;
		end
		used_rdata_q <= used_mem[used_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (hnd_we) begin
			hnd_mem[hnd_wr_addr] <= hnd_wdata;
		end
		hnd_rdata_q <= hnd_mem[hnd_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_id_q <= '0;
			max_id_q <= ID_W'(63);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_ID) begin
				max_id_q <= pwdata[ID_W-1:0];
			end else begin
				min_id_q <= pwdata[ID_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			row_q      <= '0;
			op_q       <= '0;
			slot_q     <= '0;
			hnd_q      <= '0;
			done       <= 1'b0;
			status     <= STAT_OK;
			fd_result  <= NO_FD;
			handle_out <= '0;
			known      <= 1'b0;
			ref_add    <= '0;
			ref_drop   <= '0;
		end else begin
			done       <= 1'b0;
			status     <= STAT_OK;
			fd_result  <= NO_FD;
			handle_out <= '0;
			known      <= 1'b0;
			ref_add    <= '0;
			ref_drop   <= '0;
			unique case (state_q)
				ST_CLEAR: begin
					row_q <= row_q + ROW_AW'(1);
					if (row_q == LAST_ROW) begin
						row_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q   <= op;
						slot_q <= fd_off[ID_W-1:0];
						hnd_q  <= handle;
						row_q  <= '0;
						if (op == OP_ALLOC) begin
							if (span_n == '0) begin
								done   <= 1'b1;
								status <= STAT_NONE_FREE;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (op == OP_ATTACH || op == OP_REPLACE ||
						             op == OP_REMOVE || op == OP_LOOKUP) begin
							if (fd_in) begin
								state_q <= ST_EXEC;
							end else begin
								done   <= 1'b1;
								status <= STAT_RANGE;
							end
						end else begin
							done <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						done      <= 1'b1;
						fd_result <= FDR_W'(min_id_q) + alloc_slot;
						state_q   <= ST_IDLE;
					end else if (next_base < span_n) begin
						row_q <= row_q + ROW_AW'(1);
					end else begin
						done    <= 1'b1;
						status  <= STAT_NONE_FREE;
						state_q <= ST_IDLE;
					end
				end
				ST_EXEC: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
					case (op_q)
						OP_ATTACH: begin
							if (cur_used && !cur_null) begin
								status <= STAT_HAS_HND;
							end else begin
								ref_add <= hnd_q;
							end
						end
						OP_REPLACE: begin
							if (!cur_used || cur_null) begin
								status <= STAT_UNKNOWN;
							end else if (hnd_rdata_q != hnd_q) begin
								ref_drop <= hnd_rdata_q;
								ref_add  <= hnd_q;
							end
						end
						OP_REMOVE: begin
							if (!cur_used) begin
								status <= STAT_UNKNOWN;
							end else begin
								ref_drop <= hnd_rdata_q;
							end
						end
						default: begin
							if (!cur_used) begin
								status <= STAT_UNKNOWN;
							end else begin
								known      <= 1'b1;
								handle_out <= hnd_rdata_q;
							end
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_finish_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q == ST_SCAN || state_q == ST_EXEC) && state_q == ST_IDLE) |-> done)
		else $error("item finished without a result strobe");

	a_fail_no_fd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (fd_result == NO_FD))
		else $error("failed item reports a descriptor");

	a_known_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && known) |-> (status == STAT_OK && ref_add == '0 && ref_drop == '0))
		else $error("lookup result mixed with other fields");

	a_used_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		used_we |-> (state_q != ST_IDLE))
		else $error("used-bit memory written while idle");

	a_single_hnd_write: assert property (@(posedge clk) disable iff (!arst_n)
		hnd_we |=> (state_q == ST_IDLE && done))
		else $error("handle write not followed by a result");

endmodule

// File: tb/tb_lowest_free_descriptor_allocator.sv
// self-checking testbench for the lowest-free descriptor allocator
module tb_lowest_free_descriptor_allocator;
	import lfda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HB = HANDLE_BITS_DEF;
	localparam int SETTLE = 4;

	typedef enum logic [1:0] {CMD_ITEM, CMD_CFG, CMD_DRAIN} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   fd;
		logic [HB-1:0]     hnd;
		logic              reg_sel;
		logic [CFG_W-1:0]  value;
		logic [7:0]        gap_pct;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FDR_W-1:0]    fd_result;
		logic [HB-1:0]       handle_out;
		logic                known;
		logic [HB-1:0]       ref_add;
		logic [HB-1:0]       ref_drop;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0] pwdata = '0;
	logic [CFG_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [OP_W-1:0] op = '0;
	logic [ID_W-1:0] fd = '0;
	logic [HB-1:0] handle = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic signed [FDR_W-1:0] fd_result;
	logic [HB-1:0] handle_out;
	logic known;
	logic [HB-1:0] ref_add;
	logic [HB-1:0] ref_drop;

	cmd_t pending_cmds[$];
	reply_t expected_replies[$];
	int errors = 0;

	bit used_map[DEPTH_DEF];
	logic [HB-1:0] handle_tbl[DEPTH_DEF];
	logic [ID_W-1:0] cfg_min;
	logic [ID_W-1:0] cfg_max;

	lowest_free_descriptor_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .op(op), .fd(fd), .handle(handle),
		.done(done), .status(status), .fd_result(fd_result),
		.handle_out(handle_out), .known(known), .ref_add(ref_add), .ref_drop(ref_drop)
	);

	always #5 clk = ~clk;

	task automatic allocator_reset();
		cfg_min = 10'd0;
		cfg_max = 10'd63;
		for (int i = 0; i < DEPTH_DEF; i++) begin
			used_map[i] = 1'b0;
			handle_tbl[i] = '0;
		end
	endtask

	function automatic int managed_span(int lo, int hi);
		int n;
		if (hi < lo)
			return 0;
		n = hi - lo + 1;
		return (n > DEPTH_DEF) ? DEPTH_DEF : n;
	endfunction

	function automatic reply_t predict_reply(logic [OP_W-1:0] op_i, logic [ID_W-1:0] fd_i,
			logic [HB-1:0] h_i);
		reply_t r;
		int n;
		int slot;
		bit found;
		bit managed;
		r.status = STAT_OK;
		r.fd_result = NO_FD;
		r.handle_out = '0;
		r.known = 1'b0;
		r.ref_add = '0;
		r.ref_drop = '0;
		slot = int'(fd_i) - int'(cfg_min);
		managed = fd_i >= cfg_min && fd_i <= cfg_max && slot < DEPTH_DEF;
		case (op_i)
			OP_ALLOC: begin
				n = managed_span(cfg_min, cfg_max);
				r.status = STAT_NONE_FREE;
				found = 1'b0;
				for (int i = 0; i < n; i++) begin
					if (!found && !used_map[i]) begin
						found = 1'b1;
						used_map[i] = 1'b1;
						handle_tbl[i] = '0;
						r.fd_result = FDR_W'(int'(cfg_min) + i);
						r.status = STAT_OK;
					end
				end
			end
			OP_ATTACH, OP_REPLACE, OP_REMOVE, OP_LOOKUP: begin
				if (!managed) begin
					r.status = STAT_RANGE;
				end else if (op_i == OP_ATTACH) begin
					if (used_map[slot] && handle_tbl[slot] != '0) begin
						r.status = STAT_HAS_HND;
					end else begin
						used_map[slot] = 1'b1;
						handle_tbl[slot] = h_i;
						r.ref_add = h_i;
					end
				end else if (op_i == OP_REPLACE) begin
					if (!used_map[slot] || handle_tbl[slot] == '0) begin
						r.status = STAT_UNKNOWN;
					end else if (handle_tbl[slot] != h_i) begin
						r.ref_drop = handle_tbl[slot];
						r.ref_add = h_i;
						handle_tbl[slot] = h_i;
					end
				end else if (op_i == OP_REMOVE) begin
					if (!used_map[slot]) begin
						r.status = STAT_UNKNOWN;
					end else begin
						r.ref_drop = handle_tbl[slot];
						used_map[slot] = 1'b0;
						handle_tbl[slot] = '0;
					end
				end else begin
					if (!used_map[slot]) begin
						r.status = STAT_UNKNOWN;
					end else begin
						r.known = 1'b1;
						r.handle_out = handle_tbl[slot];
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// driver
	int gap_left;
	int quiet;
	bit gap_taken;
	bit acc;
	cmd_t cur;
	logic nxt_start;
	logic nxt_psel;
	logic nxt_pen;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= '0;
			pwdata <= '0;
			op <= '0;
			fd <= '0;
			handle <= '0;
			gap_left = 0;
			quiet = 0;
			gap_taken = 1'b0;
			allocator_reset();
		end else begin
			acc = start && !busy;
			nxt_start = start && !acc;
			nxt_psel = psel;
			nxt_pen = penable;
			if (acc) begin
				expected_replies = {expected_replies, predict_reply(op, fd, handle)};
				void'(pending_cmds.pop_front());
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_MAX_ID)
						cfg_max = pwdata[ID_W-1:0];
					else
						cfg_min = pwdata[ID_W-1:0];
				end
				nxt_psel = 1'b0;
				nxt_pen = 1'b0;
				void'(pending_cmds.pop_front());
			end else if (psel) begin
				nxt_pen = 1'b1;
			end
			quiet = (expected_replies.size() == 0 && !start) ? quiet + 1 : 0;
			if (!nxt_start && !nxt_psel && pending_cmds.size() > 0) begin
				cur = pending_cmds[0];
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					case (cur.kind)
						CMD_ITEM: begin
							if (!gap_taken && $urandom_range(0, 99) < cur.gap_pct) begin
								gap_left = $urandom_range(1, 14) - 1;
								gap_taken = 1'b1;
							end else begin
								nxt_start = 1'b1;
								op <= cur.op;
								fd <= cur.fd;
								handle <= cur.hnd;
								gap_taken = 1'b0;
							end
						end
						CMD_CFG: begin
							if (quiet >= SETTLE) begin
								nxt_psel = 1'b1;
								nxt_pen = 1'b0;
								pwrite <= 1'b1;
								paddr <= {cur.reg_sel, 2'b00};
								pwdata <= cur.value;
							end
						end
						default: begin
							if (quiet >= SETTLE)
								void'(pending_cmds.pop_front());
						end
					endcase
				end
			end
			start <= nxt_start;
			psel <= nxt_psel;
			penable <= nxt_pen;
		end
	end

	// monitor
	reply_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("result with nothing expected", {29'd0, status}, 32'd0);
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.status)
					report_mismatch("status", {29'd0, status}, {29'd0, want.status});
				if (fd_result !== want.fd_result)
					report_mismatch("fd_result", {21'd0, fd_result},
						{21'd0, want.fd_result});
				if (handle_out !== want.handle_out)
					report_mismatch("handle_out", {16'd0, handle_out},
						{16'd0, want.handle_out});
				if (known !== want.known)
					report_mismatch("known", {31'd0, known}, {31'd0, want.known});
				if (ref_add !== want.ref_add)
					report_mismatch("ref_add", {16'd0, ref_add}, {16'd0, want.ref_add});
				if (ref_drop !== want.ref_drop)
					report_mismatch("ref_drop", {16'd0, ref_drop}, {16'd0, want.ref_drop});
			end
		end
	end

	task automatic push_item(logic [OP_W-1:0] o, int f, logic [HB-1:0] h, int gap);
		cmd_t c;
		c = '0;
		c.kind = CMD_ITEM;
		c.op = o;
		c.fd = ID_W'(f);
		c.hnd = h;
		c.gap_pct = 8'(gap);
		pending_cmds = {pending_cmds, c};
	endtask

	task automatic push_drain();
		cmd_t c;
		c = '0;
		c.kind = CMD_DRAIN;
		pending_cmds = {pending_cmds, c};
	endtask

	task automatic push_range(int lo, int hi);
		cmd_t c;
		c = '0;
		c.kind = CMD_CFG;
		c.reg_sel = REG_MIN_ID;
		c.value = CFG_W'(lo);
		pending_cmds = {pending_cmds, c};
		c.reg_sel = REG_MAX_ID;
		c.value = CFG_W'(hi);
		pending_cmds = {pending_cmds, c};
	endtask

	function automatic int pick_fd(int lo, int hi);
		int n;
		int r;
		n = managed_span(lo, hi);
		r = $urandom_range(0, 99);
		if (r < 75 && n > 0)
			return lo + $urandom_range(0, n - 1);
		if (r < 88)
			return $urandom_range(0, 1023);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 1023;
			2: return (lo - 1) & 10'h3ff;
			3: return (hi + 1) & 10'h3ff;
			default: return (lo + DEPTH_DEF) & 10'h3ff;
		endcase
	endfunction

	function automatic logic [HB-1:0] pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return '0;
		if (r < 35)
			return HB'($urandom_range(1, 3));
		if (r < 42)
			return '1;
		return HB'($urandom);
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return OP_ALLOC;
		if (r < 45) return OP_ATTACH;
		if (r < 60) return OP_REPLACE;
		if (r < 78) return OP_REMOVE;
		if (r < 95) return OP_LOOKUP;
		return OP_W'($urandom_range(5, 7));
	endfunction

	task automatic random_phase(int lo, int hi, int count, int gap);
		push_range(lo, hi);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2 && gap > 0)
				push_drain();
			push_item(pick_op(), pick_fd(lo, hi), pick_handle(), gap);
		end
	endtask

	initial begin
		int lo;
		push_range(0, 63);
		push_item(OP_LOOKUP, 0, '0, 0);
		push_item(OP_ALLOC, 0, '0, 0);
		push_item(OP_ALLOC, 0, '0, 0);
		push_item(OP_ATTACH, 0, 16'hffff, 0);
		push_item(OP_ATTACH, 0, 16'h0001, 0);
		push_item(OP_REPLACE, 0, 16'hffff, 0);
		push_item(OP_REPLACE, 0, 16'h1234, 0);
		push_item(OP_REPLACE, 1, 16'h5555, 0);
		push_item(OP_REPLACE, 0, 16'h0000, 0);
		push_item(OP_ATTACH, 5, 16'h0000, 0);
		push_item(OP_LOOKUP, 5, '0, 0);
		push_item(OP_REMOVE, 0, '0, 0);
		push_item(OP_REMOVE, 0, '0, 0);
		push_item(OP_ATTACH, 1023, 16'h00aa, 0);
		push_item(OP_LOOKUP, 64, '0, 0);
		push_item(OP_ATTACH, 63, 16'haaaa, 0);
		push_item(OP_LOOKUP, 63, '0, 0);
		push_item(3'd5, 3, 16'h7777, 0);
		push_item(3'd6, 3, 16'h7777, 0);
		push_item(3'd7, 1023, 16'hffff, 0);
		// empty range
		push_range(10, 5);
		push_item(OP_ALLOC, 0, '0, 0);
		push_item(OP_LOOKUP, 7, '0, 0);
		// oversized range and a single-number range at the top
		push_range(0, 1023);
		push_item(OP_ATTACH, 64, 16'h0042, 0);
		push_item(OP_LOOKUP, 63, '0, 0);
		push_range(1023, 1023);
		push_item(OP_ALLOC, 0, '0, 0);
		push_item(OP_ALLOC, 0, '0, 0);

		random_phase(0, 63, 250, 12);
		random_phase(0, 1023, 200, 0);
		random_phase(960, 1023, 150, 15);
		random_phase(1000, 1015, 100, 10);
		random_phase(1023, 1023, 60, 12);
		random_phase(500, 499, 40, 0);
		random_phase(0, 0, 60, 20);
		for (int p = 0; p < 4; p++) begin
			lo = $urandom_range(0, 1023);
			random_phase(lo, (lo + $urandom_range(0, 70)) & 10'h3ff, 80, (p % 2) * 12);
		end
		random_phase(0, 63, 170, 0);

		while (pending_cmds.size() != 0 || expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
